// ===== rtl/fcc_pkg.sv =====
// Shared constants for the frustum cube cull block.
// No dependencies; used by rtl/frustum_cube_cull.sv.
package fcc_pkg;

  localparam int NUM_REGS   = 8;   // matrix registers, two Q16.16 words each
  localparam int REG_W      = 64;  // configuration register width
  localparam int IDX_W      = 3;   // register index width
  localparam int WORD_W     = 32;  // one Q16.16 matrix word
  localparam int NORM_W     = WORD_W + 1;  // row sum or difference, exact
  localparam int NUM_ROWS   = 4;
  localparam int NUM_COLS   = 4;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;

  // Axis codes for the cube corner
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

endpackage

// ===== rtl/frustum_cube_cull.sv =====
// Frustum culling of one axis-aligned cube per item, five-stage pipeline.
// Depends on rtl/fcc_pkg.sv (constants).
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   in       | in_valid / in_ready  | corner_x, corner_y, corner_z
//   out      | out_valid / out_ready| visible
//   cfg      | cfg_we (no wait)     | cfg_index, cfg_data (64 bits)
//
// One item per cycle sustained while the output side takes items; an accepted
// item passes through five register stages (corner, plane/corner select,
// multiply, partial sum, final sum and sign test into the output register);
// the accepting edge loads the first.
// Reset clears all valid bits and the eight matrix registers (all planes
// zero, so every cube reads as visible).
// Each stage advances when it is empty or its successor advances, so a stall
// at the output fills bubbles first and never drops or repeats an item.
// Matrix registers are read directly by stage two; write them only when idle.

`default_nettype none

module frustum_cube_cull #(
  parameter int CUBE_EDGE   = 16,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input items
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]  corner_x,
  input  wire logic signed [COORD_WIDTH-1:0]  corner_y,
  input  wire logic signed [COORD_WIDTH-1:0]  corner_z,
  // result items
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           visible,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [fcc_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [fcc_pkg::REG_W-1:0]      cfg_data
);

  // Widths derived from the parameters
  localparam int EDGE_BITS = $clog2(CUBE_EDGE + 1) + 1;            // signed edge
  localparam int CEW  = ((COORD_WIDTH > EDGE_BITS) ? COORD_WIDTH : EDGE_BITS) + 1;
  localparam int NW   = fcc_pkg::NORM_W;
  localparam int PW   = NW + CEW;        // exact product width
  localparam int HW   = PW + 1;          // partial sum width
  localparam int SW   = PW + 2;          // full plane sum width
  localparam logic signed [CEW-1:0] EDGE_C = CEW'(CUBE_EDGE);

  // ---------------------------------------------------------------------
  // Matrix registers
  // ---------------------------------------------------------------------
  logic [fcc_pkg::REG_W-1:0] cfg_regs [fcc_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcc_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Unpack M[r][c]: even column in the low word, odd column in the high word
  logic signed [fcc_pkg::WORD_W-1:0] m [fcc_pkg::NUM_ROWS][fcc_pkg::NUM_COLS];

  for (genvar r = 0; r < fcc_pkg::NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < fcc_pkg::NUM_COLS; c++) begin : g_col
      assign m[r][c] = cfg_regs[2*r + c/2][fcc_pkg::WORD_W*(c%2) +: fcc_pkg::WORD_W];
    end
  end

  // ---------------------------------------------------------------------
  // Stage flow control: a stage advances when empty or its successor does
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the minimum corner
  // ---------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] mn1 [fcc_pkg::NUM_AXES];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mn1[fcc_pkg::AXIS_X] <= corner_x;
      mn1[fcc_pkg::AXIS_Y] <= corner_y;
      mn1[fcc_pkg::AXIS_Z] <= corner_z;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2..4 per plane: plane = row 3 plus (even) or minus (odd) row p/2
  // ---------------------------------------------------------------------
  logic signed [NW-1:0]  n2   [fcc_pkg::NUM_PLANES][fcc_pkg::NUM_AXES];
  logic signed [CEW-1:0] c2   [fcc_pkg::NUM_PLANES][fcc_pkg::NUM_AXES];
  logic signed [NW-1:0]  d2   [fcc_pkg::NUM_PLANES];
  logic signed [PW-1:0]  prod3[fcc_pkg::NUM_PLANES][fcc_pkg::NUM_AXES];
  logic signed [NW-1:0]  d3   [fcc_pkg::NUM_PLANES];
  logic signed [HW-1:0]  sa4  [fcc_pkg::NUM_PLANES];
  logic signed [HW-1:0]  sb4  [fcc_pkg::NUM_PLANES];
  logic [fcc_pkg::NUM_PLANES-1:0] pass5;

  for (genvar p = 0; p < fcc_pkg::NUM_PLANES; p++) begin : g_plane
    localparam int ROW = p / 2;
    localparam bit SUB = (p % 2) == 1;

    logic signed [NW-1:0] d_next;
    logic signed [SW-1:0] total;

    assign d_next = SUB
      ? ({m[3][3][fcc_pkg::WORD_W-1], m[3][3]} - {m[ROW][3][fcc_pkg::WORD_W-1], m[ROW][3]})
      : ({m[3][3][fcc_pkg::WORD_W-1], m[3][3]} + {m[ROW][3][fcc_pkg::WORD_W-1], m[ROW][3]});

    for (genvar k = 0; k < fcc_pkg::NUM_AXES; k++) begin : g_axis
      logic signed [NW-1:0]  n_next;
      logic signed [CEW-1:0] mn_ext;
      logic                  n_pos;

      assign n_next = SUB
        ? ({m[3][k][fcc_pkg::WORD_W-1], m[3][k]} - {m[ROW][k][fcc_pkg::WORD_W-1], m[ROW][k]})
        : ({m[3][k][fcc_pkg::WORD_W-1], m[3][k]} + {m[ROW][k][fcc_pkg::WORD_W-1], m[ROW][k]});
      assign n_pos  = !n_next[NW-1] && (n_next != '0);
      assign mn_ext = {{(CEW-COORD_WIDTH){mn1[k][COORD_WIDTH-1]}}, mn1[k]};

      // stage 2: normal component and positive-vertex coordinate
      always_ff @(posedge clk) begin
        if (rdy2) begin
          n2[p][k] <= n_next;
          c2[p][k] <= n_pos ? (mn_ext + EDGE_C) : mn_ext;
        end
      end

      // stage 3: exact product
      always_ff @(posedge clk) begin
        if (rdy3) begin
          prod3[p][k] <= PW'(n2[p][k]) * PW'(c2[p][k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy2) d2[p] <= d_next;
      if (rdy3) d3[p] <= d2[p];
    end

    // stage 4: two partial sums
    always_ff @(posedge clk) begin
      if (rdy4) begin
        sa4[p] <= {prod3[p][0][PW-1], prod3[p][0]} + {prod3[p][1][PW-1], prod3[p][1]};
        sb4[p] <= {prod3[p][2][PW-1], prod3[p][2]}
                + {{(HW-NW){d3[p][NW-1]}}, d3[p]};
      end
    end

    // stage 5: plane passes when the full sum is non-negative
    assign total    = {sa4[p][HW-1], sa4[p]} + {sb4[p][HW-1], sb4[p]};
    assign pass5[p] = !total[SW-1];
  end

  always_ff @(posedge clk) begin
    if (rdy5) visible <= &pass5;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Full throughput whenever the output side takes items
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although output is ready");

  // A valid multiply stage blocked downstream keeps its item and products
  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3 && $stable(prod3[0][0]) && $stable(d3[5]))
    else $error("stage 3 lost or changed an item under stall");

  // An item leaving stage 2 lands in stage 3
  a_stage2_moves: assert property (@(posedge clk) disable iff (rst)
    v2 && rdy3 |=> v3)
    else $error("item dropped between stage 2 and stage 3");

  // Output register only refreshes when it was free or just taken
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && v4 |=> out_valid && v4)
    else $error("pipeline advanced into an occupied output");

endmodule

`default_nettype wire
